FILE: rtl/core/fps_pkg.sv
// ----------------------------------------------------------------------------
// fps_pkg
// Shared constants, point record and control types of the farthest point
// sampler.
// ----------------------------------------------------------------------------
package fps_pkg;

    localparam int MAX_POINTS = 64;
    localparam int COORD_W    = 24;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int DIST_W     = 50;
    localparam int MAG_W      = COORD_W + 1;
    localparam int SQ_W       = 2 * MAG_W;
    localparam int PIPE_DEPTH = 3;
    localparam int RING_LEN   = MAX_POINTS + PIPE_DEPTH;
    localparam int PASS_W     = $clog2(RING_LEN);
    localparam int KEEP_W     = 7;
    localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd16;

    // One stored point as it travels around the ring.
    typedef struct packed {
        logic                      valid;
        logic                      used;
        logic [IDX_W-1:0]          idx;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [DIST_W-1:0]         near_dist;
    } point_t;

    // Control from the sequencer to the distance stages.
    typedef struct packed {
        logic                      shift;
        logic                      clear;
        logic                      upd;
        logic                      init;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cz;
        logic [IDX_W-1:0]          cidx;
    } pipe_ctrl_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ALL,
        ST_MINX,
        ST_DIST,
        ST_EMIT
    } state_t;

endpackage

FILE: rtl/core/fps_cell.sv
// ----------------------------------------------------------------------------
// fps_cell
// One storage cell of the point ring; takes its neighbor's point on shift.
// ----------------------------------------------------------------------------
module fps_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           shift,
    input  logic           clear,
    input  fps_pkg::point_t d,
    output fps_pkg::point_t q
);

    fps_pkg::point_t q_reg;
    fps_pkg::point_t q_next;

    always_comb begin
        q_next = q_reg;
        if (shift) begin
            q_next = d;
        end
        if (clear) begin
            q_next.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg.valid <= 1'b0;
        end else begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

FILE: rtl/core/fps_dist_pipe.sv
// ----------------------------------------------------------------------------
// fps_dist_pipe
// Three ring slots that compute the squared distance of each passing point
// to the chosen point and fold it into the point's nearest distance.
// ----------------------------------------------------------------------------
module fps_dist_pipe (
    input  logic               aclk,
    input  logic               aresetn,
    input  fps_pkg::pipe_ctrl_t ctrl,
    input  fps_pkg::point_t    d_in,
    output fps_pkg::point_t    d_out
);

    fps_pkg::point_t a_pt_reg, b_pt_reg, c_pt_reg;
    fps_pkg::point_t a_pt_next, b_pt_next, c_pt_next;
    logic [fps_pkg::MAG_W-1:0] a_mx_reg, a_my_reg, a_mz_reg;
    logic [fps_pkg::MAG_W-1:0] a_mx_next, a_my_next, a_mz_next;
    logic [fps_pkg::SQ_W-1:0]  b_sx_reg, b_sy_reg, b_sz_reg;
    logic [fps_pkg::SQ_W-1:0]  b_sx_next, b_sy_next, b_sz_next;
    logic signed [fps_pkg::MAG_W-1:0] dx, dy, dz;
    logic [fps_pkg::DIST_W-1:0] sum;

    // Stage A: absolute coordinate differences.
    always_comb begin
        dx = {d_in.x[fps_pkg::COORD_W-1], d_in.x} - {ctrl.cx[fps_pkg::COORD_W-1], ctrl.cx};
        dy = {d_in.y[fps_pkg::COORD_W-1], d_in.y} - {ctrl.cy[fps_pkg::COORD_W-1], ctrl.cy};
        dz = {d_in.z[fps_pkg::COORD_W-1], d_in.z} - {ctrl.cz[fps_pkg::COORD_W-1], ctrl.cz};
        a_mx_next = dx[fps_pkg::MAG_W-1] ? fps_pkg::MAG_W'(-dx) : fps_pkg::MAG_W'(dx);
        a_my_next = dy[fps_pkg::MAG_W-1] ? fps_pkg::MAG_W'(-dy) : fps_pkg::MAG_W'(dy);
        a_mz_next = dz[fps_pkg::MAG_W-1] ? fps_pkg::MAG_W'(-dz) : fps_pkg::MAG_W'(dz);
        a_pt_next = d_in;
    end

    // Stage B: squares.
    always_comb begin
        b_sx_next = a_mx_reg * a_mx_reg;
        b_sy_next = a_my_reg * a_my_reg;
        b_sz_next = a_mz_reg * a_mz_reg;
        b_pt_next = a_pt_reg;
    end

    // Stage C: sum, keep the nearer distance, mark the chosen point.
    always_comb begin
        sum = fps_pkg::DIST_W'(b_sx_reg) + fps_pkg::DIST_W'(b_sy_reg)
            + fps_pkg::DIST_W'(b_sz_reg);
        c_pt_next = b_pt_reg;
        if (ctrl.upd) begin
            if (ctrl.init || sum < b_pt_reg.near_dist) begin
                c_pt_next.near_dist = sum;
            end
            if (b_pt_reg.idx == ctrl.cidx) begin
                c_pt_next.used = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_pt_reg.valid <= 1'b0;
            b_pt_reg.valid <= 1'b0;
            c_pt_reg.valid <= 1'b0;
        end else if (ctrl.clear) begin
            a_pt_reg.valid <= 1'b0;
            b_pt_reg.valid <= 1'b0;
            c_pt_reg.valid <= 1'b0;
        end else if (ctrl.shift) begin
            a_pt_reg <= a_pt_next;
            b_pt_reg <= b_pt_next;
            c_pt_reg <= c_pt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            a_mx_reg <= a_mx_next;
            a_my_reg <= a_my_next;
            a_mz_reg <= a_mz_next;
            b_sx_reg <= b_sx_next;
            b_sy_reg <= b_sy_next;
            b_sz_reg <= b_sz_next;
        end
    end

    assign d_out = c_pt_reg;

endmodule

FILE: rtl/core/farthest_point_sampler.sv
// ----------------------------------------------------------------------------
// farthest_point_sampler
// Loads a cluster of 3D points and emits a farthest point subset of it.
// ----------------------------------------------------------------------------
// Load: one point item per cycle, no result until the last point.
// Keep-all case: points leave in load order, one per cycle while the output register is free.
// Sampling: one full ring pass per selected point, then the point waits in the
//   EMIT state until it is handed to the output register.
// Reset: empty store, keep_count = 16, output empty; no clearing pass.
// ----------------------------------------------------------------------------
module farthest_point_sampler (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [fps_pkg::KEEP_W-1:0]        cfg_wr_data,
    // point items in
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [fps_pkg::COORD_W-1:0] s_pos_x,
    input  logic signed [fps_pkg::COORD_W-1:0] s_pos_y,
    input  logic signed [fps_pkg::COORD_W-1:0] s_pos_z,
    input  logic                              s_in_last,
    // selected point items out
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [fps_pkg::COORD_W-1:0] m_out_x,
    output logic signed [fps_pkg::COORD_W-1:0] m_out_y,
    output logic signed [fps_pkg::COORD_W-1:0] m_out_z,
    output logic                              m_out_last,
    output logic                              m_overflow
);

    // The store is a ring: MAX_POINTS cells followed by the three distance
    // stages, all advancing together on a ring shift. A full pass of RING_LEN
    // shifts brings every point through the stages once and back to its cell.

    fps_pkg::state_t state_reg, state_next;

    logic [fps_pkg::KEEP_W-1:0] keep_reg, keep_next;
    logic [fps_pkg::CNT_W-1:0]  loaded_reg, loaded_next;
    logic                       dropped_reg, dropped_next;
    logic                       ovf_reg, ovf_next;
    logic [fps_pkg::KEEP_W-1:0] n_reg, n_next;
    logic [fps_pkg::KEEP_W-1:0] target_reg, target_next;
    logic [fps_pkg::KEEP_W-1:0] cnt_reg, cnt_next;
    logic [fps_pkg::PASS_W-1:0] pass_reg, pass_next;
    logic                       sel_last_reg, sel_last_next;

    // chosen point of the current pass
    logic signed [fps_pkg::COORD_W-1:0] ch_x_reg, ch_y_reg, ch_z_reg;
    logic signed [fps_pkg::COORD_W-1:0] ch_x_next, ch_y_next, ch_z_next;
    logic [fps_pkg::IDX_W-1:0]          ch_idx_reg, ch_idx_next;

    // running best candidate of the current pass
    logic                               bst_found_reg, bst_found_next;
    logic [fps_pkg::DIST_W-1:0]         bst_dist_reg, bst_dist_next;
    logic signed [fps_pkg::COORD_W-1:0] bst_x_reg, bst_y_reg, bst_z_reg;
    logic signed [fps_pkg::COORD_W-1:0] bst_x_next, bst_y_next, bst_z_next;
    logic [fps_pkg::IDX_W-1:0]          bst_idx_reg, bst_idx_next;

    // output register
    logic                               m_valid_reg, m_valid_next;
    logic signed [fps_pkg::COORD_W-1:0] m_x_reg, m_y_reg, m_z_reg;
    logic signed [fps_pkg::COORD_W-1:0] m_x_next, m_y_next, m_z_next;
    logic                               m_last_reg, m_last_next;
    logic                               m_ovf_reg, m_ovf_next;

    // ring datapath
    fps_pkg::point_t     cell_q [fps_pkg::MAX_POINTS];
    fps_pkg::point_t     cell0_d;
    fps_pkg::point_t     load_pt;
    fps_pkg::point_t     pipe_out;
    fps_pkg::point_t     tail;
    fps_pkg::pipe_ctrl_t pctrl;

    // control strobes
    logic accept_in;
    logic out_free;
    logic load_shift;
    logic ring_shift;
    logic emit_all;
    logic emit_sel;
    logic last_all;
    logic done_clear;
    logic pass_end;
    logic cand_ok;
    logic better;

    assign tail = cell_q[fps_pkg::MAX_POINTS-1];

    // ------------------------------------------------------------------------
    // Ring of storage cells
    // ------------------------------------------------------------------------
    always_comb begin
        load_pt       = pipe_out;
        load_pt.valid = 1'b1;
        load_pt.used  = 1'b0;
        load_pt.idx   = loaded_reg[fps_pkg::IDX_W-1:0];
        load_pt.x     = s_pos_x;
        load_pt.y     = s_pos_y;
        load_pt.z     = s_pos_z;
        cell0_d       = (state_reg == fps_pkg::ST_LOAD) ? load_pt : pipe_out;
    end

    for (genvar gi = 0; gi < fps_pkg::MAX_POINTS; gi++) begin : g_cell
        if (gi == 0) begin : g_head
            fps_cell u_cell (
                .aclk   (aclk),
                .aresetn(aresetn),
                .shift  (load_shift | ring_shift),
                .clear  (done_clear),
                .d      (cell0_d),
                .q      (cell_q[gi])
            );
        end else begin : g_body
            fps_cell u_cell (
                .aclk   (aclk),
                .aresetn(aresetn),
                .shift  (load_shift | ring_shift),
                .clear  (done_clear),
                .d      (cell_q[gi-1]),
                .q      (cell_q[gi])
            );
        end
    end

    fps_dist_pipe u_pipe (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctrl   (pctrl),
        .d_in   (tail),
        .d_out  (pipe_out)
    );

    // ------------------------------------------------------------------------
    // Output and control strobes
    // ------------------------------------------------------------------------
    always_comb begin
        s_ready    = (state_reg == fps_pkg::ST_LOAD);
        accept_in  = s_valid & s_ready;
        out_free   = !m_valid_reg | m_ready;
        load_shift = accept_in && (loaded_reg < fps_pkg::CNT_W'(fps_pkg::MAX_POINTS));
        last_all   = (cnt_reg + 1'b1) == n_reg;
        emit_all   = (state_reg == fps_pkg::ST_ALL) && tail.valid && out_free;
        emit_sel   = (state_reg == fps_pkg::ST_EMIT) && out_free;
        done_clear = (emit_all && last_all) || (emit_sel && sel_last_reg);
        pass_end   = pass_reg == fps_pkg::PASS_W'(fps_pkg::RING_LEN - 1);

        case (state_reg)
            fps_pkg::ST_MINX,
            fps_pkg::ST_DIST: ring_shift = 1'b1;
            // hold the ring while a point waits for the output register
            fps_pkg::ST_ALL:  ring_shift = !tail.valid || (out_free && !last_all);
            default:          ring_shift = 1'b0;
        endcase

        pctrl.shift = ring_shift;
        pctrl.clear = done_clear;
        pctrl.upd   = (state_reg == fps_pkg::ST_DIST);
        pctrl.init  = (cnt_reg == fps_pkg::KEEP_W'(1));
        pctrl.cx    = ch_x_reg;
        pctrl.cy    = ch_y_reg;
        pctrl.cz    = ch_z_reg;
        pctrl.cidx  = ch_idx_reg;

        // candidate leaving the distance stages
        cand_ok = pipe_out.valid && !pipe_out.used;
        if (state_reg == fps_pkg::ST_MINX) begin
            better = !bst_found_reg || (pipe_out.x < bst_x_reg) ||
                     ((pipe_out.x == bst_x_reg) && (pipe_out.idx < bst_idx_reg));
        end else begin
            better = !bst_found_reg || (pipe_out.near_dist > bst_dist_reg) ||
                     ((pipe_out.near_dist == bst_dist_reg) &&
                      ((pipe_out.x < bst_x_reg) ||
                       ((pipe_out.x == bst_x_reg) && (pipe_out.idx < bst_idx_reg))));
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_x    = m_x_reg;
    assign m_out_y    = m_y_reg;
    assign m_out_z    = m_z_reg;
    assign m_out_last = m_last_reg;
    assign m_overflow = m_ovf_reg;

    // ------------------------------------------------------------------------
    // Next state and datapath registers
    // ------------------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        keep_next      = cfg_wr_en ? cfg_wr_data : keep_reg;
        loaded_next    = loaded_reg;
        dropped_next   = dropped_reg;
        ovf_next       = ovf_reg;
        n_next         = n_reg;
        target_next    = target_reg;
        cnt_next       = cnt_reg;
        pass_next      = pass_reg;
        sel_last_next  = sel_last_reg;
        ch_x_next      = ch_x_reg;
        ch_y_next      = ch_y_reg;
        ch_z_next      = ch_z_reg;
        ch_idx_next    = ch_idx_reg;
        bst_found_next = bst_found_reg;
        bst_dist_next  = bst_dist_reg;
        bst_x_next     = bst_x_reg;
        bst_y_next     = bst_y_reg;
        bst_z_next     = bst_z_reg;
        bst_idx_next   = bst_idx_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_x_next       = m_x_reg;
        m_y_next       = m_y_reg;
        m_z_next       = m_z_reg;
        m_last_next    = m_last_reg;
        m_ovf_next     = m_ovf_reg;

        case (state_reg)
            fps_pkg::ST_LOAD: begin
                if (accept_in) begin
                    // store the point, or drop it when the store is full
                    loaded_next  = load_shift ? loaded_reg + 1'b1 : loaded_reg;
                    dropped_next = dropped_reg | !load_shift;
                    if (s_in_last) begin
                        n_next        = fps_pkg::KEEP_W'(loaded_next);
                        ovf_next      = dropped_next;
                        cnt_next      = '0;
                        pass_next     = '0;
                        bst_found_next = 1'b0;
                        target_next   = (keep_reg == '0) ? fps_pkg::KEEP_W'(1) : keep_reg;
                        state_next    = (keep_reg >= fps_pkg::KEEP_W'(loaded_next))
                                        ? fps_pkg::ST_ALL : fps_pkg::ST_MINX;
                    end
                end
            end
            fps_pkg::ST_ALL: begin
                if (emit_all) begin
                    m_valid_next = 1'b1;
                    m_x_next     = tail.x;
                    m_y_next     = tail.y;
                    m_z_next     = tail.z;
                    m_last_next  = last_all;
                    m_ovf_next   = ovf_reg;
                    cnt_next     = cnt_reg + 1'b1;
                    if (last_all) begin
                        state_next = fps_pkg::ST_LOAD;
                    end
                end
            end
            fps_pkg::ST_MINX,
            fps_pkg::ST_DIST: begin
                if (cand_ok && better) begin
                    bst_found_next = 1'b1;
                    bst_dist_next  = pipe_out.near_dist;
                    bst_x_next     = pipe_out.x;
                    bst_y_next     = pipe_out.y;
                    bst_z_next     = pipe_out.z;
                    bst_idx_next   = pipe_out.idx;
                end
                pass_next = pass_reg + 1'b1;
                if (pass_end) begin
                    // take the pass winner as the next chosen point
                    ch_x_next     = bst_x_next;
                    ch_y_next     = bst_y_next;
                    ch_z_next     = bst_z_next;
                    ch_idx_next   = bst_idx_next;
                    sel_last_next = (cnt_reg + 1'b1) == target_reg;
                    state_next    = fps_pkg::ST_EMIT;
                end
            end
            fps_pkg::ST_EMIT: begin
                if (emit_sel) begin
                    m_valid_next   = 1'b1;
                    m_x_next       = ch_x_reg;
                    m_y_next       = ch_y_reg;
                    m_z_next       = ch_z_reg;
                    m_last_next    = sel_last_reg;
                    m_ovf_next     = ovf_reg;
                    cnt_next       = cnt_reg + 1'b1;
                    pass_next      = '0;
                    bst_found_next = 1'b0;
                    state_next     = sel_last_reg ? fps_pkg::ST_LOAD : fps_pkg::ST_DIST;
                end
            end
            default: begin
                state_next = fps_pkg::ST_LOAD;
            end
        endcase

        // end of cluster: drop the stored points
        if (done_clear) begin
            loaded_next  = '0;
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fps_pkg::ST_LOAD;
            keep_reg    <= fps_pkg::KEEP_RESET;
            loaded_reg  <= '0;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            pass_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            keep_reg    <= keep_next;
            loaded_reg  <= loaded_next;
            dropped_reg <= dropped_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            pass_reg    <= pass_next;
        end
    end

    always_ff @(posedge aclk) begin
        ovf_reg       <= ovf_next;
        n_reg         <= n_next;
        target_reg    <= target_next;
        sel_last_reg  <= sel_last_next;
        ch_x_reg      <= ch_x_next;
        ch_y_reg      <= ch_y_next;
        ch_z_reg      <= ch_z_next;
        ch_idx_reg    <= ch_idx_next;
        bst_found_reg <= bst_found_next;
        bst_dist_reg  <= bst_dist_next;
        bst_x_reg     <= bst_x_next;
        bst_y_reg     <= bst_y_next;
        bst_z_reg     <= bst_z_next;
        bst_idx_reg   <= bst_idx_next;
        m_x_reg       <= m_x_next;
        m_y_reg       <= m_y_next;
        m_z_reg       <= m_z_next;
        m_last_reg    <= m_last_next;
        m_ovf_reg     <= m_ovf_next;
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the farthest point sampler: clusters of random and
// hand-built points are sent under random bursts and output stalls, each
// selected point is predicted by a behavioral sampler and compared in order.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic signed [fps_pkg::COORD_W-1:0] x;
        logic signed [fps_pkg::COORD_W-1:0] y;
        logic signed [fps_pkg::COORD_W-1:0] z;
        logic                               last;
    } pt_item_t;

    typedef struct packed {
        logic signed [fps_pkg::COORD_W-1:0] x;
        logic signed [fps_pkg::COORD_W-1:0] y;
        logic signed [fps_pkg::COORD_W-1:0] z;
        logic                               last;
        logic                               ovf;
    } sel_item_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [fps_pkg::KEEP_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [fps_pkg::COORD_W-1:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic s_in_last = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [fps_pkg::COORD_W-1:0] m_out_x, m_out_y, m_out_z;
    logic m_out_last, m_overflow;

    farthest_point_sampler dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_pos_z(s_pos_z),
        .s_in_last(s_in_last),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_x(m_out_x), .m_out_y(m_out_y), .m_out_z(m_out_z),
        .m_out_last(m_out_last), .m_overflow(m_overflow)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Pending point items and predicted selections.
    pt_item_t  pending_pts[$];
    sel_item_t expected_sel[$];
    int        mismatches = 0;
    int        sel_seen = 0;
    int        clusters_sent = 0;

    // Sampler state mirrored in the bench.
    logic signed [fps_pkg::COORD_W-1:0] held_x[fps_pkg::MAX_POINTS];
    logic signed [fps_pkg::COORD_W-1:0] held_y[fps_pkg::MAX_POINTS];
    logic signed [fps_pkg::COORD_W-1:0] held_z[fps_pkg::MAX_POINTS];
    int          held_cnt = 0;
    bit          held_dropped = 0;
    logic [fps_pkg::KEEP_W-1:0] keep_cfg = fps_pkg::KEEP_RESET;

    // Control knobs for the driver and the sink.
    bit sender_hold = 0;
    bit pause_armed = 0;
    int sink_hold_cycles = 0;
    int sink_mode = 0;

    function automatic longint unsigned sq_dist(int a, int b);
        longint d0, d1, d2;
        d0 = longint'(held_x[a]) - longint'(held_x[b]);
        d1 = longint'(held_y[a]) - longint'(held_y[b]);
        d2 = longint'(held_z[a]) - longint'(held_z[b]);
        return longint'(d0 * d0) + longint'(d1 * d1) + longint'(d2 * d2);
    endfunction

    function automatic void push_sel(int i, bit last);
        sel_item_t s;
        s.x = held_x[i]; s.y = held_y[i]; s.z = held_z[i];
        s.last = last; s.ovf = held_dropped;
        expected_sel.insert(expected_sel.size(), s);
    endfunction

    // Store one accepted point; on the last point, predict the selections.
    task automatic sample_cluster(pt_item_t p);
        int n, tgt, first, best;
        bit used[fps_pkg::MAX_POINTS];
        longint unsigned near[fps_pkg::MAX_POINTS];
        longint unsigned d;
        if (held_cnt < fps_pkg::MAX_POINTS) begin
            held_x[held_cnt] = p.x; held_y[held_cnt] = p.y; held_z[held_cnt] = p.z;
            held_cnt++;
        end else begin
            held_dropped = 1;
        end
        if (!p.last) return;
        n = held_cnt;
        if (keep_cfg >= n) begin
            for (int i = 0; i < n; i++) push_sel(i, i + 1 == n);
        end else begin
            tgt = (keep_cfg == 0) ? 1 : keep_cfg;
            first = 0;
            for (int i = 1; i < n; i++) if (held_x[i] < held_x[first]) first = i;
            for (int i = 0; i < n; i++) begin
                used[i] = 0;
                near[i] = sq_dist(i, first);
            end
            used[first] = 1;
            push_sel(first, tgt == 1);
            for (int c = 1; c < tgt; c++) begin
                best = -1;
                for (int i = 0; i < n; i++) begin
                    if (used[i]) continue;
                    if (best < 0 || near[i] > near[best] ||
                        (near[i] == near[best] && held_x[i] < held_x[best]))
                        best = i;
                end
                if (best < 0) break;
                used[best] = 1;
                for (int i = 0; i < n; i++) begin
                    d = sq_dist(i, best);
                    if (d < near[i]) near[i] = d;
                end
                push_sel(best, c + 1 == tgt);
            end
        end
        held_cnt = 0;
        held_dropped = 0;
        clusters_sent++;
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    // Driver: bursts with random gaps; hold valid and payload until accepted.
    int burst_left = 0, gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !s_ready)) begin
            if (s_valid) begin
                sample_cluster(pending_pts.pop_front());
                // pause after the armed cluster until its selections are out
                if (pause_armed && s_in_last) begin
                    pause_armed = 0;
                    sender_hold = 1;
                end
            end
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_pts.size() > 0 && !sender_hold) begin
                s_valid   <= 1'b1;
                s_pos_x   <= pending_pts[0].x;
                s_pos_y   <= pending_pts[0].y;
                s_pos_z   <= pending_pts[0].z;
                s_in_last <= pending_pts[0].last;
                if (burst_left > 0) burst_left--;
                else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor and sink: compare each accepted selection with the oldest one.
    always @(posedge aclk) begin
        sel_item_t w;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                sel_seen++;
                if (expected_sel.size() == 0) begin
                    report("unexpected item", 32'({m_out_last, m_out_x[7:0]}), 32'd0);
                end else begin
                    w = expected_sel.pop_front();
                    if (m_out_x !== w.x) report("out_x", 32'(m_out_x), 32'(w.x));
                    if (m_out_y !== w.y) report("out_y", 32'(m_out_y), 32'(w.y));
                    if (m_out_z !== w.z) report("out_z", 32'(m_out_z), 32'(w.z));
                    if (m_out_last !== w.last)
                        report("out_last", 32'(m_out_last), 32'(w.last));
                    if (m_overflow !== w.ovf)
                        report("overflow", 32'(m_overflow), 32'(w.ovf));
                end
            end
            if (sink_hold_cycles > 0) begin
                sink_hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                case (sink_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic logic signed [fps_pkg::COORD_W-1:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return fps_pkg::COORD_W'($urandom_range(0, 15)) - 24'sd8;
            default: return fps_pkg::COORD_W'($urandom);
        endcase
    endfunction

    task automatic add_point(logic signed [fps_pkg::COORD_W-1:0] x,
                             logic signed [fps_pkg::COORD_W-1:0] y,
                             logic signed [fps_pkg::COORD_W-1:0] z, bit last);
        pt_item_t p;
        p.x = x; p.y = y; p.z = z; p.last = last;
        pending_pts.insert(pending_pts.size(), p);
    endtask

    task automatic add_cluster(int n);
        for (int i = 0; i < n; i++) add_point(rnd_coord(), rnd_coord(), rnd_coord(), i == n - 1);
    endtask

    task automatic drain();
        while (pending_pts.size() > 0 || s_valid || expected_sel.size() > 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_keep(logic [fps_pkg::KEEP_W-1:0] k);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= k;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        keep_cfg = k;
    endtask

    initial begin
        int sent;
        int n;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reset keep count of 16, extremes and ties.
        add_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
        add_point(24'sh800000, 24'sh800000, 24'sh800000, 1'b0);
        add_point(24'sh800000, 24'sd0, 24'sd0, 1'b0);
        add_point(24'sd0, 24'sd0, 24'sd0, 1'b1);
        drain();
        // Keep zero still yields the point of least x; ties on x go to earlier load.
        write_keep(7'd0);
        add_point(24'sd5, 24'sd1, 24'sd1, 1'b0);
        add_point(-24'sd3, 24'sd2, 24'sd2, 1'b0);
        add_point(-24'sd3, 24'sd9, 24'sd9, 1'b1);
        drain();
        // Equal distances: the tie on x goes to the earlier load.
        write_keep(7'd3);
        add_point(24'sd0, 24'sd0, 24'sd0, 1'b0);
        add_point(24'sd10, 24'sd0, 24'sd0, 1'b0);
        add_point(-24'sd10, 24'sd0, 24'sd0, 1'b0);
        add_point(24'sd0, 24'sd10, 24'sd0, 1'b0);
        add_point(24'sd0, -24'sd10, 24'sd0, 1'b1);
        drain();
        // Keep above range acts as keep all; single point cluster.
        write_keep(7'd127);
        add_point(24'sh123456, -24'sd1, 24'sh555555, 1'b1);
        add_cluster(5);
        drain();

        // Store full: 66 points with keep all (last two dropped), then 65 with keep few.
        write_keep(7'd64);
        add_cluster(66);
        drain();
        write_keep(7'd4);
        add_cluster(65);
        drain();

        // Random clusters, cycling through idling styles and keep counts.
        for (int ph = 0; ph < 6; ph++) begin
            sink_mode = ph % 3;
            write_keep((ph == 1) ? 7'd1 : (ph == 4) ? 7'd65 :
                       fps_pkg::KEEP_W'($urandom_range(1, 12)));
            sent = 0;
            while (sent < 14) begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
                add_cluster(n);
                sent += n;
            end
            // Hold off the output for a long stretch while clusters are still queued.
            if (ph == 2) sink_hold_cycles = 600;
            drain();
        end

        // Pause the sender after one cluster until every selection has come.
        pause_armed = 1;
        add_cluster(8);
        add_cluster(5);
        while (!sender_hold) @(posedge aclk);
        while (expected_sel.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        sender_hold = 0;
        drain();

        $display("Sent %0d clusters, checked %0d selected points, %0d mismatches.",
                 clusters_sent, sel_seen, mismatches);
        if (mismatches == 0 && expected_sel.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #40ms;
        $display("Verification failed");
        $finish;
    end
endmodule

FILE: files.f
rtl/core/fps_pkg.sv
rtl/core/fps_cell.sv
rtl/core/fps_dist_pipe.sv
rtl/core/farthest_point_sampler.sv
verif/tb_top.sv
